>>> src/abl_pkg.sv
package abl_pkg;

  localparam int unsigned MAX_BLOCK_SAMPLES_DEF = 1024;

  localparam int unsigned RAW_W    = 32;
  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned PCM_W    = 16;
  localparam int unsigned LEVEL_W  = 8;
  localparam int unsigned SMOOTH_W = 16;
  localparam int unsigned SHIFT_W  = 5;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_SHIFT      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_WEIGHT = 1'd1;

  localparam logic [SHIFT_W-1:0]  LEVEL_SHIFT_RST      = 5'd7;
  localparam logic [WEIGHT_W-1:0] SMOOTHING_WEIGHT_RST = 16'd58982;

  localparam logic signed [PCM_W-1:0] PCM_MAX = 16'sh7fff;
  localparam logic signed [PCM_W-1:0] PCM_MIN = -16'sh8000;
  localparam logic [LEVEL_W-1:0]      LEVEL_MAX = 8'd255;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CLAMP,
    ST_MUL_OLD,
    ST_MUL_NEW,
    ST_SUM,
    ST_PUSH
  } state_e;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic clamp;
    logic mul_old;
    logic mul_new;
    logic sum;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

>>> src/abl_if.sv
interface abl_in_if;
  import abl_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [RAW_W-1:0] raw_sample;
  logic                    block_last;

  modport source (output valid, output raw_sample, output block_last, input ready);
  modport sink   (input valid, input raw_sample, input block_last, output ready);
endinterface

interface abl_out_if;
  import abl_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [PCM_W-1:0] pcm_sample;
  logic                    block_end;
  logic [LEVEL_W-1:0]      average_level;
  logic [LEVEL_W-1:0]      peak_level;
  logic [SMOOTH_W-1:0]     smoothed_level;

  modport source (output valid, output pcm_sample, output block_end, output average_level,
                  output peak_level, output smoothed_level, input ready);
  modport sink   (input valid, input pcm_sample, input block_end, input average_level,
                  input peak_level, input smoothed_level, output ready);
endinterface

>>> src/abl_ctrl.sv
module abl_ctrl
  import abl_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = status_i.last ? ST_DIV : ST_PUSH;
        end
      end
      ST_DIV: begin
        if (status_i.div_done) begin
          state_d = ST_CLAMP;
        end
      end
      ST_CLAMP:   state_d = ST_MUL_OLD;
      ST_MUL_OLD: state_d = ST_MUL_NEW;
      ST_MUL_NEW: state_d = ST_SUM;
      ST_SUM:     state_d = ST_PUSH;
      ST_PUSH: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_DIV:     cmd_o.div_step = 1'b1;
      ST_CLAMP:   cmd_o.clamp    = 1'b1;
      ST_MUL_OLD: cmd_o.mul_old  = 1'b1;
      ST_MUL_NEW: cmd_o.mul_new  = 1'b1;
      ST_SUM:     cmd_o.sum      = 1'b1;
      ST_PUSH:    cmd_o.push     = status_i.out_free;
      default:    cmd_o          = '0;
    endcase
  end

endmodule

>>> src/abl_datapath.sv
module abl_datapath
  import abl_pkg::*;
#(
  parameter int unsigned MaxBlockSamples = MAX_BLOCK_SAMPLES_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_W-1:0]        cfg_data_i,
  input  logic signed [RAW_W-1:0] raw_sample_i,
  input  logic                    block_last_i,
  input  cmd_t                    cmd_i,
  output status_t                 status_o,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic signed [PCM_W-1:0] pcm_sample_o,
  output logic                    block_end_o,
  output logic [LEVEL_W-1:0]      average_level_o,
  output logic [LEVEL_W-1:0]      peak_level_o,
  output logic [SMOOTH_W-1:0]     smoothed_level_o
);

  localparam int unsigned CntW  = $clog2(MaxBlockSamples + 1);
  localparam int unsigned SumW  = SAMPLE_W + CntW;
  localparam int unsigned StepW = $clog2(SumW + 1);
  localparam int unsigned P1W   = SMOOTH_W + WEIGHT_W;
  localparam int unsigned P2W   = SMOOTH_W + WEIGHT_W + 1;
  localparam int unsigned AccW  = P2W + 1;

  // configuration
  logic [SHIFT_W-1:0]  level_shift_q;
  logic [WEIGHT_W-1:0] weight_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_shift_q <= LEVEL_SHIFT_RST;
      weight_q      <= SMOOTHING_WEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LEVEL_SHIFT:      level_shift_q <= cfg_data_i[SHIFT_W-1:0];
        REG_SMOOTHING_WEIGHT: weight_q      <= cfg_data_i[WEIGHT_W-1:0];
        default:              ;
      endcase
    end
  end

  // sample conversion
  logic signed [SAMPLE_W-1:0] sample;
  logic [SAMPLE_W-1:0]        mag;
  logic signed [PCM_W-1:0]    pcm;

  assign sample = raw_sample_i[RAW_W-1:RAW_W-SAMPLE_W];
  assign mag    = sample[SAMPLE_W-1] ? SAMPLE_W'(-sample) : SAMPLE_W'(sample);

  always_comb begin
    if ((&sample[SAMPLE_W-1:PCM_W-1]) || !(|sample[SAMPLE_W-1:PCM_W-1])) begin
      pcm = sample[PCM_W-1:0];
    end else begin
      pcm = sample[SAMPLE_W-1] ? PCM_MIN : PCM_MAX;
    end
  end

  // block accumulators
  logic [SumW-1:0]     sum_q, sum_d;
  logic [SAMPLE_W-1:0] peak_q, peak_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [CntW-1:0]     count_inc;
  logic                last_q;
  logic                last_eff;
  logic signed [PCM_W-1:0] pcm_q;

  assign count_inc = count_q + CntW'(1);
  assign last_eff  = block_last_i || (count_inc == CntW'(MaxBlockSamples));

  always_comb begin
    sum_d   = sum_q;
    peak_d  = peak_q;
    count_d = count_q;
    if (cmd_i.accept) begin
      sum_d   = sum_q + SumW'(mag);
      peak_d  = (mag > peak_q) ? mag : peak_q;
      count_d = count_inc;
    end else if (cmd_i.clamp) begin
      sum_d   = '0;
      peak_d  = '0;
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      peak_q  <= '0;
      count_q <= '0;
      last_q  <= 1'b0;
    end else begin
      sum_q   <= sum_d;
      peak_q  <= peak_d;
      count_q <= count_d;
      if (cmd_i.accept) begin
        last_q <= last_eff;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pcm_q <= pcm;
    end
  end

  // restoring divider, one quotient bit per cycle; quotient ends up in dvd_q
  logic [SumW-1:0]  dvd_q;
  logic [CntW-1:0]  rem_q;
  logic [CntW:0]    rem_sh;
  logic             rem_ge;
  logic [StepW-1:0] step_q;

  assign rem_sh = {rem_q, dvd_q[SumW-1]};
  assign rem_ge = rem_sh >= {1'b0, count_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.accept) begin
      step_q <= '0;
    end else if (cmd_i.div_step) begin
      step_q <= step_q + StepW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      dvd_q <= sum_d;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[SumW-2:0], rem_ge};
      rem_q <= rem_ge ? CntW'(rem_sh - {1'b0, count_q}) : rem_sh[CntW-1:0];
    end
  end

  // level scaling
  logic [SumW-1:0]     avg_shifted;
  logic [SAMPLE_W-1:0] peak_shifted;
  logic [LEVEL_W-1:0]  avg_lvl_q, peak_lvl_q;

  assign avg_shifted  = dvd_q >> level_shift_q;
  assign peak_shifted = peak_q >> level_shift_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clamp) begin
      avg_lvl_q  <= (|avg_shifted[SumW-1:LEVEL_W]) ? LEVEL_MAX : avg_shifted[LEVEL_W-1:0];
      peak_lvl_q <= (|peak_shifted[SAMPLE_W-1:LEVEL_W]) ? LEVEL_MAX
                                                         : peak_shifted[LEVEL_W-1:0];
    end
  end

  // smoothing: old * w + (level << 8) * (1 - w), rounded half up
  logic [SMOOTH_W-1:0] smooth_q;
  logic [P1W-1:0]      p_old_q;
  logic [P2W-1:0]      p_new_q;
  logic [WEIGHT_W:0]   weight_inv;
  logic [AccW-1:0]     acc;

  assign weight_inv = {1'b1, {WEIGHT_W{1'b0}}} - {1'b0, weight_q};
  assign acc = AccW'(p_old_q) + AccW'(p_new_q) + AccW'(1 << (SMOOTH_W - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_old) begin
      p_old_q <= P1W'(smooth_q) * P1W'(weight_q);
    end
    if (cmd_i.mul_new) begin
      p_new_q <= P2W'({avg_lvl_q, {LEVEL_W{1'b0}}}) * P2W'(weight_inv);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_q <= '0;
    end else if (cmd_i.sum) begin
      smooth_q <= acc[SMOOTH_W+WEIGHT_W-1:WEIGHT_W];
    end
  end

  // output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      pcm_sample_o     <= pcm_q;
      block_end_o      <= last_q;
      average_level_o  <= last_q ? avg_lvl_q : '0;
      peak_level_o     <= last_q ? peak_lvl_q : '0;
      smoothed_level_o <= last_q ? smooth_q : '0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o.last     = last_eff;
  assign status_o.div_done = (step_q == StepW'(SumW - 1));
  assign status_o.out_free = !out_valid_q || out_ready_i;

endmodule

>>> src/audio_block_level_meter_top.sv
// Block level meter for 32-bit I2S words. Each accepted word yields one result transaction
// holding the 16-bit saturated PCM sample; on the last word of a block (block_last, or
// the block reaching MaxBlockSamples words) the result also carries the average level,
// the peak level and the Q8.8 smoothed level, with block_end set. A word that does not
// close a block goes from acceptance to the PUSH state and into the output register,
// and the next word can be taken once the controller is back in IDLE. A word that closes
// a block passes through DIV, CLAMP, MUL_OLD, MUL_NEW, SUM and PUSH, where DIV runs
// SumW = 24 + clog2(MaxBlockSamples + 1) steps of the bit-serial divider
// that forms the block mean; the two smoothing products are formed one after the other,
// in MUL_OLD and then MUL_NEW. One word is in work at a time; a finished
// result may wait in the output register while the next word is taken, and a result that
// finds the output register still full waits in PUSH until the sink takes the old one.
module audio_block_level_meter_top
  import abl_pkg::*;
#(
  parameter int unsigned MaxBlockSamples = MAX_BLOCK_SAMPLES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  abl_in_if.sink               in_i,
  abl_out_if.source            out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  abl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  abl_datapath #(
    .MaxBlockSamples (MaxBlockSamples)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .raw_sample_i     (in_i.raw_sample),
    .block_last_i     (in_i.block_last),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_ready_i      (out_o.ready),
    .out_valid_o      (out_o.valid),
    .pcm_sample_o     (out_o.pcm_sample),
    .block_end_o      (out_o.block_end),
    .average_level_o  (out_o.average_level),
    .peak_level_o     (out_o.peak_level),
    .smoothed_level_o (out_o.smoothed_level)
  );

endmodule

>>> bench/audio_block_level_meter_top_tb.sv
`timescale 1ns / 100ps

module audio_block_level_meter_top_tb;
  import abl_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int unsigned DRAIN_CYCLES    = 64;
  localparam int unsigned WORDS_PER_PHASE = 140;
  localparam int unsigned NUM_PHASES      = 8;
  localparam int unsigned LONG_PHASE      = 4;
  localparam int unsigned NUM_ROWS        = 25;

  typedef struct packed {
    logic signed [PCM_W-1:0] pcm;
    logic                    block_end;
    logic [LEVEL_W-1:0]      avg;
    logic [LEVEL_W-1:0]      peak;
    logic [SMOOTH_W-1:0]     smooth;
  } meter_result_t;

  typedef enum logic [0:0] {ROW_WORD, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [RAW_W-1:0]     raw;
    logic                 last;
    logic                 typed;
    meter_result_t        res;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
  } stim_row_t;

  // rows with typed results hold values that follow directly from the word and the registers
  localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{ROW_WORD, 32'h0000_0000, 1'b1, 1'b1, '{16'sh0000, 1'b1, 8'd0, 8'd0, 16'd0}, 1'b0, 16'd0},
    '{ROW_WORD, 32'h7fff_ffff, 1'b0, 1'b1, '{16'sh7fff, 1'b0, 8'd0, 8'd0, 16'd0}, 1'b0, 16'd0},
    '{ROW_WORD, 32'h8000_0000, 1'b1, 1'b1,
      '{16'sh8000, 1'b1, 8'd255, 8'd255, 16'd6528}, 1'b0, 16'd0},
    '{ROW_WORD, 32'h007f_ff00, 1'b0, 1'b1, '{16'sh7fff, 1'b0, 8'd0, 8'd0, 16'd0}, 1'b0, 16'd0},
    '{ROW_WORD, 32'h0080_0000, 1'b0, 1'b1, '{16'sh7fff, 1'b0, 8'd0, 8'd0, 16'd0}, 1'b0, 16'd0},
    '{ROW_WORD, 32'hff80_0000, 1'b0, 1'b1, '{16'sh8000, 1'b0, 8'd0, 8'd0, 16'd0}, 1'b0, 16'd0},
    '{ROW_WORD, 32'hff7f_ff00, 1'b0, 1'b1, '{16'sh8000, 1'b0, 8'd0, 8'd0, 16'd0}, 1'b0, 16'd0},
    '{ROW_WORD, 32'hffff_ffff, 1'b0, 1'b1, '{16'shffff, 1'b0, 8'd0, 8'd0, 16'd0}, 1'b0, 16'd0},
    '{ROW_WORD, 32'h0000_00ff, 1'b1, 1'b0, '0, 1'b0, 16'd0},
    '{ROW_CFG,  32'h0000_0000, 1'b0, 1'b0, '0, REG_LEVEL_SHIFT, 16'd0},
    '{ROW_CFG,  32'h0000_0000, 1'b0, 1'b0, '0, REG_SMOOTHING_WEIGHT, 16'd0},
    '{ROW_WORD, 32'h0000_0100, 1'b1, 1'b1, '{16'sh0001, 1'b1, 8'd1, 8'd1, 16'd256}, 1'b0, 16'd0},
    '{ROW_WORD, 32'h00ff_ff00, 1'b1, 1'b1,
      '{16'sh7fff, 1'b1, 8'd255, 8'd255, 16'd65280}, 1'b0, 16'd0},
    '{ROW_CFG,  32'h0000_0000, 1'b0, 1'b0, '0, REG_SMOOTHING_WEIGHT, 16'hffff},
    // upper bits beyond the register width are dropped, leaving a shift of 31
    '{ROW_CFG,  32'h0000_0000, 1'b0, 1'b0, '0, REG_LEVEL_SHIFT, 16'hffff},
    '{ROW_WORD, 32'h1234_5678, 1'b1, 1'b0, '0, 1'b0, 16'd0},
    '{ROW_CFG,  32'h0000_0000, 1'b0, 1'b0, '0, REG_LEVEL_SHIFT, 16'd23},
    '{ROW_WORD, 32'h8000_0000, 1'b0, 1'b0, '0, 1'b0, 16'd0},
    '{ROW_WORD, 32'h7fff_ff00, 1'b1, 1'b0, '0, 1'b0, 16'd0},
    '{ROW_CFG,  32'h0000_0000, 1'b0, 1'b0, '0, REG_LEVEL_SHIFT, 16'd7},
    '{ROW_CFG,  32'h0000_0000, 1'b0, 1'b0, '0, REG_SMOOTHING_WEIGHT, 16'd58982},
    '{ROW_WORD, 32'ha5a5_a5a5, 1'b0, 1'b0, '0, 1'b0, 16'd0},
    '{ROW_WORD, 32'h5a5a_5a5a, 1'b1, 1'b0, '0, 1'b0, 16'd0},
    '{ROW_WORD, 32'h0000_0001, 1'b0, 1'b0, '0, 1'b0, 16'd0},
    '{ROW_WORD, 32'h80ff_ffff, 1'b1, 1'b0, '0, 1'b0, 16'd0}
  };

  localparam logic [SHIFT_W-1:0]  PHASE_SHIFT  [6] = '{5'd7, 5'd0, 5'd31, 5'd23, 5'd15, 5'd3};
  localparam logic [WEIGHT_W-1:0] PHASE_WEIGHT [6] =
    '{16'd58982, 16'd0, 16'd65535, 16'd1, 16'd60000, 16'd32768};

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  abl_in_if  in_ch ();
  abl_out_if out_ch ();

  audio_block_level_meter_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // predictor state
  logic [47:0]         mag_total;
  logic [SAMPLE_W-1:0] mag_max;
  int unsigned         words_in_block;
  logic [SMOOTH_W-1:0] ema_q8;
  logic [SHIFT_W-1:0]  shift_cfg;
  logic [WEIGHT_W-1:0] weight_cfg;

  meter_result_t block_results [$];

  bit          gaps_on;
  bit          stalls_on;
  int unsigned stall_left;
  int unsigned cycle_count;
  int unsigned mismatches;
  int unsigned words_sent;
  int unsigned results_checked;
  int unsigned block_ends_seen;
  int unsigned settings_used;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [LEVEL_W-1:0] to_level(input logic [47:0] v);
    logic [47:0] scaled;
    scaled = v >> shift_cfg;
    return (scaled > 48'd255) ? LEVEL_MAX : scaled[LEVEL_W-1:0];
  endfunction

  function automatic meter_result_t meter_step(input logic [RAW_W-1:0] raw, input logic last);
    logic signed [SAMPLE_W-1:0] sample;
    logic [SAMPLE_W-1:0]        mag;
    logic [47:0]                mean;
    logic [47:0]                blend;
    meter_result_t              res;
    sample = raw[RAW_W-1:8];
    // magnitude of the most negative sample still fits the unsigned 24 bits
    mag = sample[SAMPLE_W-1] ? -sample : sample;
    mag_total = mag_total + 48'(mag);
    if (mag > mag_max) mag_max = mag;
    words_in_block = words_in_block + 1;
    res = '0;
    if (sample > 24'sd32767) res.pcm = PCM_MAX;
    else if (sample < -24'sd32768) res.pcm = PCM_MIN;
    else res.pcm = sample[PCM_W-1:0];
    if (last || words_in_block >= MAX_BLOCK_SAMPLES_DEF) begin
      mean = mag_total / 48'(words_in_block);
      res.block_end = 1'b1;
      res.avg = to_level(mean);
      res.peak = to_level(48'(mag_max));
      blend = 48'(ema_q8) * 48'(weight_cfg)
            + (48'(res.avg) << 8) * (48'd65536 - 48'(weight_cfg)) + 48'd32768;
      ema_q8 = blend[31:16];
      res.smooth = ema_q8;
      mag_total = '0;
      mag_max = '0;
      words_in_block = 0;
    end
    return res;
  endfunction

  function automatic logic [RAW_W-1:0] random_word(input bit loud);
    logic [RAW_W-1:0]      w;
    logic [SAMPLE_W-1:0]   hi;
    w = $urandom;
    if (loud && $urandom_range(0, 3) != 0) return {w[8] ? 24'h7fffff : 24'h800000, w[7:0]};
    case ($urandom_range(0, 4))
      0: return {{12{w[31]}}, w[19:0]};
      1: begin
        case ($urandom_range(0, 5))
          0: hi = 24'h007fff;
          1: hi = 24'h008000;
          2: hi = 24'hff8000;
          3: hi = 24'hff7fff;
          4: hi = 24'h7fffff;
          default: hi = 24'h800000;
        endcase
        return {hi, w[7:0]};
      end
      default: return w;
    endcase
  endfunction

  task automatic send_word(input logic [RAW_W-1:0] raw, input logic last,
                           input logic typed, input meter_result_t typed_res);
    meter_result_t predicted;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.raw_sample <= raw;
    in_ch.block_last <= last;
    do @(posedge clk_i); while (!in_ch.ready);
    predicted = meter_step(raw, last);
    block_results.push_back(typed ? typed_res : predicted);
    words_sent++;
  endtask

  task automatic send_block(input int unsigned len, input bit loud);
    for (int unsigned i = 0; i < len; i++) begin
      send_word(random_word(loud), i == len - 1, 1'b0, '0);
    end
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (block_results.size() != 0) @(posedge clk_i);
  endtask

  // the wait after each write keeps the enable from being lowered and raised at once
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_LEVEL_SHIFT) shift_cfg = data[SHIFT_W-1:0];
    else if (idx == REG_SMOOTHING_WEIGHT) weight_cfg = data[WEIGHT_W-1:0];
    settings_used++;
    @(posedge clk_i);
  endtask

  // sink side: ready drops in bursts of random length, started only while stalls_on is set
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 4) == 0) begin
      stall_left   <= $urandom_range(0, 4);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    meter_result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      results_checked++;
      if (out_ch.block_end) block_ends_seen++;
      if (block_results.size() == 0) begin
        $error("result transaction with nothing expected: pcm_sample %0d", out_ch.pcm_sample);
        mismatches++;
      end else begin
        want = block_results.pop_front();
        if (out_ch.pcm_sample !== want.pcm) begin
          $error("pcm_sample: expected %0d, got %0d", want.pcm, out_ch.pcm_sample);
          mismatches++;
        end
        if (out_ch.block_end !== want.block_end) begin
          $error("block_end: expected %0d, got %0d", want.block_end, out_ch.block_end);
          mismatches++;
        end
        if (out_ch.average_level !== want.avg) begin
          $error("average_level: expected %0d, got %0d", want.avg, out_ch.average_level);
          mismatches++;
        end
        if (out_ch.peak_level !== want.peak) begin
          $error("peak_level: expected %0d, got %0d", want.peak, out_ch.peak_level);
          mismatches++;
        end
        if (out_ch.smoothed_level !== want.smooth) begin
          $error("smoothed_level: expected %0d, got %0d", want.smooth, out_ch.smoothed_level);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("cycle limit hit with %0d results outstanding", block_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [RAW_W-1:0] upper;
    logic [SHIFT_W-1:0]  shift_val;
    logic [WEIGHT_W-1:0] weight_val;
    int unsigned      phase_words;
    int unsigned      len;
    in_ch.valid      <= 1'b0;
    in_ch.raw_sample <= '0;
    in_ch.block_last <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= '0;
    cfg_data_i       <= '0;
    rst_ni           <= 1'b0;
    mismatches       = 0;
    words_sent       = 0;
    results_checked  = 0;
    block_ends_seen  = 0;
    settings_used    = 0;
    mag_total        = '0;
    mag_max          = '0;
    words_in_block   = 0;
    ema_q8           = '0;
    shift_cfg        = LEVEL_SHIFT_RST;
    weight_cfg       = SMOOTHING_WEIGHT_RST;
    gaps_on          = 1'b1;
    stalls_on        = 1'b1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED_ROWS[i]) begin
      if (DIRECTED_ROWS[i].kind == ROW_CFG) begin
        wait_idle();
        write_register(DIRECTED_ROWS[i].idx, DIRECTED_ROWS[i].data);
      end else begin
        send_word(DIRECTED_ROWS[i].raw, DIRECTED_ROWS[i].last,
                  DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);
      end
    end

    for (int unsigned phase = 0; phase < NUM_PHASES; phase++) begin
      wait_idle();
      if (phase < 6) begin
        shift_val  = PHASE_SHIFT[phase];
        weight_val = PHASE_WEIGHT[phase];
      end else begin
        shift_val  = SHIFT_W'($urandom_range(0, 31));
        weight_val = WEIGHT_W'($urandom);
      end
      // junk in the upper data bits must not reach the shift register
      upper = $urandom;
      write_register(REG_LEVEL_SHIFT, {upper[CFG_W-SHIFT_W-1:0], shift_val});
      write_register(REG_SMOOTHING_WEIGHT, weight_val);
      gaps_on   = (phase != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      stalls_on = (phase != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      // one block longer than the maximum length, so the meter closes it on its own
      if (phase == LONG_PHASE) send_block(MAX_BLOCK_SAMPLES_DEF + 6, 1'b1);
      phase_words = 0;
      while (phase_words < WORDS_PER_PHASE) begin
        case ($urandom_range(0, 9))
          0: len = 1;
          1: len = $urandom_range(60, 200);
          default: len = $urandom_range(2, 24);
        endcase
        send_block(len, $urandom_range(0, 7) == 0);
        phase_words += len;
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d words sent, %0d result transactions checked, %0d of them block ends",
             words_sent, results_checked, block_ends_seen);
    $display("%0d register writes, %0d mismatches", settings_used, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
